FILE: design/dlr_pkg.sv
// Dashed line rasterizer: shared widths, codes, command struct and FSM state type.
// Used by dlr_ctrl, dlr_datapath and dashed_line_rasterizer.
package dlr_pkg;

	localparam int COORD_BITS = 12;
	localparam int ADDR_BITS  = 24;
	localparam int COLOR_BITS = 32;
	localparam int WIDTH_BITS = 13;
	localparam int MODE_BITS  = 2;
	localparam int STYLE_BITS = 2;
	localparam int ON_BITS    = 13;
	localparam int GAP_BITS   = 2;

	localparam int PIX_BITS = COORD_BITS + 1;
	localparam int CUR_BITS = COORD_BITS + 2;
	localparam int CNT_BITS = COORD_BITS;
	localparam int REM_BITS = COORD_BITS + 1;
	localparam int MUL_BITS = CUR_BITS + WIDTH_BITS + 1;
	localparam int SUM_BITS = (MUL_BITS > ADDR_BITS) ? MUL_BITS : ADDR_BITS;

	localparam int IN_FIELD_BITS  = 4 * COORD_BITS + COLOR_BITS + STYLE_BITS;
	localparam int IN_DATA_BITS   = (IN_FIELD_BITS + 7) / 8 * 8;
	localparam int OUT_FIELD_BITS = 2 * PIX_BITS + ADDR_BITS + COLOR_BITS + 1;
	localparam int OUT_DATA_BITS  = (OUT_FIELD_BITS + 7) / 8 * 8;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	localparam logic REG_DRAW_MODE    = 1'b0;
	localparam logic REG_BUFFER_WIDTH = 1'b1;

	localparam logic [MODE_BITS-1:0] MODE_OVERWRITE = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_XOR       = 2'd1;

	localparam logic [STYLE_BITS-1:0] STYLE_SOLID = 2'd0;
	localparam logic [STYLE_BITS-1:0] STYLE_SHORT = 2'd1;
	localparam logic [STYLE_BITS-1:0] STYLE_DASH  = 2'd2;
	localparam logic [STYLE_BITS-1:0] STYLE_DOT   = 2'd3;

	localparam logic [GAP_BITS-1:0]   GAP_RELOAD  = 2'd3;
	localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 13'd800;
	localparam logic [ON_BITS-1:0]    ON_RESET    = 13'd6000;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD
	} state_t;

	typedef struct packed {
		logic accept;
		logic mul;
		logic out_load;
	} dlr_cmd_t;

	function automatic logic [ON_BITS-1:0] on_length(input logic [STYLE_BITS-1:0] style);
		logic [ON_BITS-1:0] len;
		case (style)
			STYLE_SOLID: len = 13'd6000;
			STYLE_SHORT: len = 13'd4;
			STYLE_DASH:  len = 13'd9;
			STYLE_DOT:   len = 13'd1;
			default:     len = 13'd6000;
		endcase
		return len;
	endfunction

endpackage

FILE: design/dlr_ctrl.sv
// Dashed line rasterizer controller: accept / multiply / address add sequence
// and output register occupancy. Depends on dlr_pkg.
module dlr_ctrl import dlr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	output dlr_cmd_t cmd
);

	state_t state_q, state_nxt;
	logic   out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load)
				out_vld_q <= 1'b1;
			else if (m_tready)
				out_vld_q <= 1'b0;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: if (s_tvalid) state_nxt = ST_MUL;
			ST_MUL:  state_nxt = ST_ADD;
			ST_ADD:  if (!out_vld_q || m_tready) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready     = 1'b0;
		cmd.accept   = 1'b0;
		cmd.mul      = 1'b0;
		cmd.out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
			end
			ST_MUL: cmd.mul = 1'b1;
			ST_ADD: cmd.out_load = !out_vld_q || m_tready;
			default: ;
		endcase
	end

	assign m_tvalid = out_vld_q;

endmodule

FILE: design/dlr_datapath.sv
// Dashed line rasterizer datapath: config registers, line state, incremental
// minor-axis remainder, dash counters, address multiply-add, output register. Depends on dlr_pkg.
module dlr_datapath import dlr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dlr_cmd_t                 cmd,
	input  logic                     cfg_valid,
	input  logic                     cfg_index,
	input  logic [WIDTH_BITS-1:0]    cfg_data,
	input  logic [IN_DATA_BITS-1:0]  s_tdata,
	input  logic                     s_tuser,
	output logic [OUT_DATA_BITS-1:0] m_tdata,
	output logic                     m_tuser,
	output logic                     m_tlast
);

	logic [MODE_BITS-1:0]  mode_q;
	logic [WIDTH_BITS-1:0] width_q;

	logic signed [COORD_BITS-1:0] start_x, start_y, end_x, end_y;
	logic [COLOR_BITS-1:0]        pen_color;
	logic [STYLE_BITS-1:0]        dash_style;

	logic                   active_q, xmaj_q, neg_x_q, neg_y_q;
	logic [CNT_BITS-1:0]    idx_q, cnt_q;
	logic signed [CUR_BITS-1:0] cur_x_q, cur_y_q;
	logic [REM_BITS-1:0]    rem_q, two_a_q, two_b_q;
	logic [COLOR_BITS-1:0]  color_q;
	logic [ON_BITS-1:0]     on_len_q, on_q;
	logic [GAP_BITS-1:0]    gap_q;

	logic signed [COORD_BITS:0] dx, dy;
	logic [COORD_BITS-1:0]      adx, ady, maj_len, min_len;
	logic                       x_major;

	logic                   draw, pix_ok, carry, last_step;
	logic [REM_BITS:0]      rem_sum;
	logic [CNT_BITS:0]      idx_inc;
	logic signed [CUR_BITS-1:0] dlt_x, dlt_y;

	logic                       valid_s1, xw_s1, done_s1;
	logic signed [CUR_BITS-1:0] px_s1, py_s1;
	logic [COLOR_BITS-1:0]      col_s1;
	logic signed [MUL_BITS-1:0] prod_s2;
	logic signed [SUM_BITS-1:0] addr_sum;

	logic                  pvalid_q, xw_q, done_q;
	logic [PIX_BITS-1:0]   pix_x_q, pix_y_q;
	logic [ADDR_BITS-1:0]  addr_q;
	logic [COLOR_BITS-1:0] wcol_q;

	assign start_x    = s_tdata[COORD_BITS-1:0];
	assign start_y    = s_tdata[2*COORD_BITS-1:COORD_BITS];
	assign end_x      = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
	assign end_y      = s_tdata[4*COORD_BITS-1:3*COORD_BITS];
	assign pen_color  = s_tdata[4*COORD_BITS+COLOR_BITS-1:4*COORD_BITS];
	assign dash_style = s_tdata[IN_FIELD_BITS-1:4*COORD_BITS+COLOR_BITS];

	always_comb begin
		dx      = (COORD_BITS+1)'(end_x) - (COORD_BITS+1)'(start_x);
		dy      = (COORD_BITS+1)'(end_y) - (COORD_BITS+1)'(start_y);
		adx     = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
		ady     = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
		x_major = adx > ady;
		maj_len = x_major ? adx : ady;
		min_len = x_major ? ady : adx;
	end

	always_comb begin
		draw      = on_q != '0;
		pix_ok    = draw && (mode_q inside {MODE_OVERWRITE, MODE_XOR});
		rem_sum   = {1'b0, rem_q} + {1'b0, two_b_q};
		carry     = rem_sum >= {1'b0, two_a_q};
		idx_inc   = {1'b0, idx_q} + 1'b1;
		last_step = idx_inc >= {1'b0, cnt_q};
		dlt_x     = (xmaj_q || carry) ? (neg_x_q ? -CUR_BITS'(1) : CUR_BITS'(1)) : '0;
		dlt_y     = (!xmaj_q || carry) ? (neg_y_q ? -CUR_BITS'(1) : CUR_BITS'(1)) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_OVERWRITE;
			width_q  <= WIDTH_RESET;
			active_q <= 1'b0;
			xmaj_q   <= 1'b0;
			neg_x_q  <= 1'b0;
			neg_y_q  <= 1'b0;
			idx_q    <= '0;
			cnt_q    <= '0;
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			rem_q    <= '0;
			two_a_q  <= '0;
			two_b_q  <= '0;
			color_q  <= '0;
			on_len_q <= ON_RESET;
			on_q     <= '0;
			gap_q    <= GAP_RELOAD;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == REG_DRAW_MODE)
					mode_q <= cfg_data[MODE_BITS-1:0];
				else
					width_q <= cfg_data;
			end
			if (cmd.accept) begin
				if (s_tuser == CMD_START) begin
					active_q <= maj_len != '0;
					xmaj_q   <= x_major;
					neg_x_q  <= dx[COORD_BITS];
					neg_y_q  <= dy[COORD_BITS];
					idx_q    <= '0;
					cnt_q    <= maj_len;
					cur_x_q  <= CUR_BITS'(start_x);
					cur_y_q  <= CUR_BITS'(start_y);
					rem_q    <= {1'b0, maj_len};
					two_a_q  <= {maj_len, 1'b0};
					two_b_q  <= {min_len, 1'b0};
					color_q  <= pen_color;
					on_len_q <= on_length(dash_style);
					on_q     <= on_length(dash_style);
					gap_q    <= GAP_RELOAD;
				end else if (active_q) begin
					if (draw) begin
						on_q  <= on_q - 1'b1;
						gap_q <= GAP_RELOAD;
					end else if (gap_q == '0) begin
						on_q <= on_len_q;
					end else begin
						gap_q <= gap_q - 1'b1;
					end
					cur_x_q  <= cur_x_q + dlt_x;
					cur_y_q  <= cur_y_q + dlt_y;
					rem_q    <= carry ? REM_BITS'(rem_sum - {1'b0, two_a_q})
						: rem_sum[REM_BITS-1:0];
					idx_q    <= idx_inc[CNT_BITS-1:0];
					active_q <= !last_step;
				end
			end
		end
	end

	// pixel capture, one result per accepted item
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			valid_s1 <= 1'b0;
			xw_s1    <= 1'b0;
			px_s1    <= '0;
			py_s1    <= '0;
			col_s1   <= '0;
			done_s1  <= 1'b1;
			if (s_tuser == CMD_START) begin
				done_s1 <= maj_len == '0;
			end else if (active_q) begin
				done_s1 <= last_step;
				if (pix_ok) begin
					valid_s1 <= 1'b1;
					xw_s1    <= mode_q == MODE_XOR;
					px_s1    <= cur_x_q;
					py_s1    <= cur_y_q;
					col_s1   <= color_q;
				end
			end
		end
		if (cmd.mul)
			prod_s2 <= MUL_BITS'(py_s1) * $signed(MUL_BITS'(width_q));
		if (cmd.out_load) begin
			pvalid_q <= valid_s1;
			xw_q     <= xw_s1;
			done_q   <= done_s1;
			pix_x_q  <= px_s1[PIX_BITS-1:0];
			pix_y_q  <= py_s1[PIX_BITS-1:0];
			addr_q   <= addr_sum[ADDR_BITS-1:0];
			wcol_q   <= col_s1;
		end
	end

	assign addr_sum = SUM_BITS'(prod_s2) + SUM_BITS'(px_s1);

	assign m_tdata = {{(OUT_DATA_BITS-OUT_FIELD_BITS){1'b0}},
		xw_q, wcol_q, addr_q, pix_y_q, pix_x_q};
	assign m_tuser = pvalid_q;
	assign m_tlast = done_q;

endmodule

FILE: design/dashed_line_rasterizer.sv
// Dashed line rasterizer top level: controller plus datapath.
// Depends on dlr_pkg, dlr_ctrl, dlr_datapath.
//
//   group  dir  handshake            payload
//   s_*    in   s_tvalid/s_tready    tdata: coordinates, colour, dash style; tuser: command
//   m_*    out  m_tvalid/m_tready    tdata: pixel, address, colour, xor; tuser: pixel_valid;
//                                    tlast: line_done
//   cfg_*  in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Each item passes through the accept, y*width multiply and address add steps, the last
// into the output register; a new item is taken only once the previous one is loaded there.
// A finished result waits in the output register while the next item is taken;
// the add step holds while that register is still full.
// Reset clears the line state and loads the register defaults; cfg writes are always taken.
module dashed_line_rasterizer import dlr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// start_x, start_y, end_x, end_y, pen_color, dash_style, zero pad
	input  logic [IN_DATA_BITS-1:0]  s_tdata,
	// command
	input  logic                     s_tuser,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// pixel_x, pixel_y, pixel_address, write_color, xor_write, zero pad
	output logic [OUT_DATA_BITS-1:0] m_tdata,
	// pixel_valid
	output logic                     m_tuser,
	output logic                     m_tlast,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic                     cfg_index,
	input  logic [WIDTH_BITS-1:0]    cfg_data
);

	dlr_cmd_t cmd;

	assign cfg_ready = 1'b1;

	dlr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	dlr_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

FILE: sim/dlr_pixel_checker.sv
`timescale 1ns / 100ps
// Pixel checker for dashed_line_rasterizer: tracks line, dash and register state from the
// accepted input and config transactions and compares every output transaction with it.
// Depends on dlr_pkg only.
module dlr_pixel_checker import dlr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	input  logic                     s_tready,
	input  logic [IN_DATA_BITS-1:0]  s_tdata,
	input  logic                     s_tuser,
	input  logic                     m_tvalid,
	input  logic                     m_tready,
	input  logic [OUT_DATA_BITS-1:0] m_tdata,
	input  logic                     m_tuser,
	input  logic                     m_tlast,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic                     cfg_index,
	input  logic [WIDTH_BITS-1:0]    cfg_data,
	output int                       mismatches,
	output int                       outstanding
);

	localparam int SCALE      = 8;

	typedef struct {
		logic                  pix_on;
		logic [PIX_BITS-1:0]   px;
		logic [PIX_BITS-1:0]   py;
		logic [ADDR_BITS-1:0]  addr;
		logic [COLOR_BITS-1:0] color;
		logic                  xw;
		logic                  done;
	} pixel_t;

	pixel_t expected_q[$];

	logic [MODE_BITS-1:0]  mode;
	logic [WIDTH_BITS-1:0] row_width;
	logic                  line_on;
	logic                  x_maj;
	logic [COLOR_BITS-1:0] line_color;
	logic [ON_BITS-1:0]    on_len;
	int                    step_idx;
	int                    step_total;
	int                    org_x;
	int                    org_y;
	int                    sdx;
	int                    sdy;
	int                    on_cnt;
	int                    gap_cnt;

	function automatic void clear_line_state();
		mode       = MODE_OVERWRITE;
		row_width  = WIDTH_RESET;
		line_on    = 1'b0;
		x_maj      = 1'b0;
		line_color = '0;
		on_len     = ON_RESET;
		step_idx   = 0;
		step_total = 0;
		org_x      = 0;
		org_y      = 0;
		sdx        = 0;
		sdy        = 0;
		on_cnt     = 0;
		gap_cnt    = GAP_RELOAD;
	endfunction

	function automatic pixel_t predict_pixel(input logic cmd, input logic [IN_DATA_BITS-1:0] d);
		pixel_t p;
		int     x1, y1, dx, dy, adx, ady;
		longint i, sx, sy, num, lx, ly, a;
		logic   draw;
		p = '{default: '0};
		if (cmd == CMD_START) begin
			x1  = $signed(d[0 +: COORD_BITS]);
			y1  = $signed(d[COORD_BITS +: COORD_BITS]);
			dx  = $signed(d[2*COORD_BITS +: COORD_BITS]) - x1;
			dy  = $signed(d[3*COORD_BITS +: COORD_BITS]) - y1;
			adx = dx < 0 ? -dx : dx;
			ady = dy < 0 ? -dy : dy;
			org_x      = x1;
			org_y      = y1;
			sdx        = dx * SCALE;
			sdy        = dy * SCALE;
			x_maj      = adx > ady;
			step_total = x_maj ? adx : ady;
			step_idx   = 0;
			line_on    = step_total != 0;
			line_color = d[4*COORD_BITS +: COLOR_BITS];
			case (d[4*COORD_BITS+COLOR_BITS +: STYLE_BITS])
				STYLE_SHORT: on_len = 13'd4;
				STYLE_DASH:  on_len = 13'd9;
				STYLE_DOT:   on_len = 13'd1;
				default:     on_len = 13'd6000;
			endcase
			on_cnt  = on_len;
			gap_cnt = GAP_RELOAD;
		end else if (line_on) begin
			i  = step_idx;
			sx = sdx < 0 ? -1 : 1;
			sy = sdy < 0 ? -1 : 1;
			if (x_maj) begin
				num = i * sx * sdy + sy * (sdx / 2);
				lx  = org_x + i * sx;
				ly  = org_y + num / sdx;
			end else begin
				num = i * sy * sdx + sx * (sdy / 2);
				lx  = org_x + num / sdy;
				ly  = org_y + i * sy;
			end
			// dash: on run, then four skipped steps, the last reloading the on count
			if (on_cnt >= 1) begin
				on_cnt--;
				gap_cnt = GAP_RELOAD;
				draw    = 1'b1;
			end else begin
				if (gap_cnt == 0)
					on_cnt = on_len;
				else
					gap_cnt--;
				draw = 1'b0;
			end
			if (draw && (mode inside {MODE_OVERWRITE, MODE_XOR})) begin
				a       = ly * longint'(row_width) + lx;
				p.pix_on = 1'b1;
				p.px     = lx[PIX_BITS-1:0];
				p.py     = ly[PIX_BITS-1:0];
				p.addr   = a[ADDR_BITS-1:0];
				p.color  = line_color;
				p.xw     = mode == MODE_XOR;
			end
			step_idx++;
			if (step_idx >= step_total)
				line_on = 1'b0;
		end
		p.done = !line_on;
		return p;
	endfunction

	task automatic check_field(input string field, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
		end
	endtask

	initial begin
		mismatches  = 0;
		outstanding = 0;
		clear_line_state();
	end

	always @(posedge clk or negedge arst_n) begin
		pixel_t want;
		if (!arst_n) begin
			clear_line_state();
			expected_q.delete();
			outstanding = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_DRAW_MODE)
					mode = cfg_data[MODE_BITS-1:0];
				else
					row_width = cfg_data;
			end
			if (s_tvalid && s_tready)
				expected_q.push_back(predict_pixel(s_tuser, s_tdata));
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected pixel transaction, expected none, got tdata %h",
						$time, m_tdata);
				end else begin
					want = expected_q.pop_front();
					check_field("pixel_valid", want.pix_on, m_tuser);
					check_field("pixel_x", want.px, m_tdata[0 +: PIX_BITS]);
					check_field("pixel_y", want.py, m_tdata[PIX_BITS +: PIX_BITS]);
					check_field("pixel_address", want.addr, m_tdata[2*PIX_BITS +: ADDR_BITS]);
					check_field("write_color", want.color,
						m_tdata[2*PIX_BITS+ADDR_BITS +: COLOR_BITS]);
					check_field("xor_write", want.xw, m_tdata[2*PIX_BITS+ADDR_BITS+COLOR_BITS]);
					check_field("line_done", want.done, m_tlast);
				end
			end
			outstanding = expected_q.size();
		end
	end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// Testbench top for dashed_line_rasterizer: clock, reset, line commands, register phases,
// random idling on both streams and the verdict. Depends on dlr_pkg, the RTL, dlr_pixel_checker.
module tb import dlr_pkg::*; ();

	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 10;
	localparam int HOLD_AT      = 80;
	localparam int HOLD_CYCLES  = 250;

	localparam logic [MODE_BITS-1:0] MODE_BLANK = 2'd2;
	localparam logic [MODE_BITS-1:0] MODE_SPARE = 2'd3;

	logic                     clk;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	logic [IN_DATA_BITS-1:0]  s_tdata;
	logic                     s_tuser;
	logic                     m_tvalid;
	logic                     m_tready;
	logic [OUT_DATA_BITS-1:0] m_tdata;
	logic                     m_tuser;
	logic                     m_tlast;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic                     cfg_index;
	logic [WIDTH_BITS-1:0]    cfg_data;

	int items_sent;
	int idle_pct;
	int stall_pct;
	int mismatches;
	int outstanding;
	int cycles;

	dashed_line_rasterizer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	dlr_pixel_checker u_pixel_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	// receiver: random stalls, plus one long hold-off to back the block up
	initial begin
		int  hold_left;
		logic hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		m_tready  = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && items_sent >= HOLD_AT) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= $urandom_range(99) >= stall_pct;
			end
		end
	end

	function automatic int rand_coord();
		return int'($urandom_range(4095)) - 2048;
	endfunction

	function automatic int near_coord(input int c);
		int d;
		d = int'($urandom_range(24)) - 12;
		if (c + d > 2047 || c + d < -2048)
			d = -d;
		return c + d;
	endfunction

	function automatic int mag(input int v);
		return v < 0 ? -v : v;
	endfunction

	function automatic logic [IN_DATA_BITS-1:0] pack_line(input int x1, y1, x2, y2,
			input logic [COLOR_BITS-1:0] color, input logic [STYLE_BITS-1:0] style);
		logic [IN_DATA_BITS-1:0] d;
		d = '0;
		d[0 +: COORD_BITS]                      = x1[COORD_BITS-1:0];
		d[COORD_BITS +: COORD_BITS]             = y1[COORD_BITS-1:0];
		d[2*COORD_BITS +: COORD_BITS]           = x2[COORD_BITS-1:0];
		d[3*COORD_BITS +: COORD_BITS]           = y2[COORD_BITS-1:0];
		d[4*COORD_BITS +: COLOR_BITS]           = color;
		d[4*COORD_BITS+COLOR_BITS +: STYLE_BITS] = style;
		return d;
	endfunction

	// called and returns at a falling edge; leaves tvalid high for the next transaction
	task automatic send_item(input logic cmd, input logic [IN_DATA_BITS-1:0] d);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= d;
		do
			@(posedge clk);
		while (!s_tready);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic start_line(input int x1, y1, x2, y2, input logic [COLOR_BITS-1:0] color,
			input logic [STYLE_BITS-1:0] style);
		send_item(CMD_START, pack_line(x1, y1, x2, y2, color, style));
	endtask

	task automatic step_line(input int n);
		logic [IN_DATA_BITS-1:0] junk;
		repeat (n) begin
			junk = IN_DATA_BITS'({$urandom, $urandom, $urandom});
			send_item(CMD_STEP, junk);
		end
	endtask

	task automatic random_lines(input int n_items);
		int goal, r, x1, y1, x2, y2, len, steps;
		goal = items_sent + n_items;
		while (items_sent < goal) begin
			r = $urandom_range(99);
			if (r < 6) begin
				step_line(1);
			end else begin
				x1 = rand_coord();
				y1 = rand_coord();
				if (r < 16) begin
					x2 = rand_coord();
					y2 = rand_coord();
				end else begin
					x2 = near_coord(x1);
					y2 = near_coord(y1);
				end
				len = mag(x2 - x1) > mag(y2 - y1) ? mag(x2 - x1) : mag(y2 - y1);
				if (len > 40)
					steps = $urandom_range(1, 24);
				else if ($urandom_range(9) == 0)
					steps = $urandom_range(0, len);
				else
					steps = len + ($urandom_range(3) == 0 ? int'($urandom_range(1, 2)) : 0);
				start_line(x1, y1, x2, y2, $urandom, STYLE_BITS'($urandom_range(3)));
				step_line(steps);
			end
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [WIDTH_BITS-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic run_phase(input logic [MODE_BITS-1:0] mode, input logic [WIDTH_BITS-1:0] width,
			input int idle, input int stall, input int n_items);
		drain();
		write_reg(REG_DRAW_MODE, WIDTH_BITS'(mode));
		write_reg(REG_BUFFER_WIDTH, width);
		cfg_valid <= 1'b0;
		idle_pct  = idle;
		stall_pct = stall;
		random_lines(n_items);
	endtask

	initial begin
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tuser    = CMD_STEP;
		s_tdata    = '0;
		cfg_valid  = 1'b0;
		cfg_index  = REG_DRAW_MODE;
		cfg_data   = '0;
		items_sent = 0;
		idle_pct   = 0;
		stall_pct  = 0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// register defaults after reset
		step_line(1);
		start_line(5, 5, 5, 5, 32'h0000_0000, STYLE_SOLID);
		step_line(1);
		start_line(-2048, -2048, 2047, 2047, 32'hFFFF_FFFF, STYLE_DOT);
		step_line(3);
		// abandons the long diagonal
		start_line(2047, 2047, 2040, 2045, 32'hA5A5_5A5A, STYLE_SHORT);
		step_line(7);
		start_line(-2048, 2047, -2045, 2040, 32'h0123_4567, STYLE_DASH);
		step_line(8);
		random_lines(230);

		run_phase(MODE_XOR, 13'd4096, 71, 0, 265);
		run_phase(MODE_BLANK, 13'd1, 0, 71, 265);
		run_phase(MODE_SPARE, 13'd0, 14, 14, 265);
		run_phase(MODE_OVERWRITE, 13'd8191, 0, 0, 265);
		run_phase(MODE_XOR, WIDTH_BITS'($urandom_range(1, 4096)), 71, 0, 265);
		run_phase(MODE_OVERWRITE, WIDTH_RESET, 0, 71, 265);
		drain();

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: dashed_line_rasterizer.f
design/dlr_pkg.sv
design/dlr_ctrl.sv
design/dlr_datapath.sv
design/dashed_line_rasterizer.sv
sim/dlr_pixel_checker.sv
sim/tb.sv
